// File: rtl/toeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package toeq_pkg;

    localparam int TIME_W = 32;
    localparam int TAG_W  = 8;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_POP    = 2'd1,
        K_PEEK   = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [TAG_W-1:0]  ev_type;
        logic [TAG_W-1:0]  ev_source;
        logic [TAG_W-1:0]  ev_dest;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry ev;
    } t_slot;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_ctrl;

endpackage

`default_nettype wire

// File: rtl/time_ordered_event_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------------
// command   | in        | start & !busy          | i_kind, i_event_time, i_event_type,
//           |           |                        | i_source_floor, i_dest_floor
// result    | out       | o_done (one cycle)     | o_status, o_out_time, o_out_type,
//           |           |                        | o_out_source, o_out_dest, o_occupancy
//
// One item per cycle: busy is never raised. Each item's result appears on the
// cycle after acceptance, set by the single compare-and-shift step of the cell
// chain. Synchronous active-low reset empties the chain (valid bits only) and
// clears the count and strobe. The receiver cannot stall; results are simply
// presented for one cycle.
module time_ordered_event_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire  [1:0]                  i_kind,
    input  wire  [toeq_pkg::TIME_W-1:0] i_event_time,
    input  wire  [toeq_pkg::TAG_W-1:0]  i_event_type,
    input  wire  [toeq_pkg::TAG_W-1:0]  i_source_floor,
    input  wire  [toeq_pkg::TAG_W-1:0]  i_dest_floor,
    output logic                        o_done,
    output logic [1:0]                  o_status,
    output logic [toeq_pkg::TIME_W-1:0] o_out_time,
    output logic [toeq_pkg::TAG_W-1:0]  o_out_type,
    output logic [toeq_pkg::TAG_W-1:0]  o_out_source,
    output logic [toeq_pkg::TAG_W-1:0]  o_out_dest,
    output logic [toeq_pkg::OCC_W-1:0]  o_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    toeq_pkg::t_ctrl  s_ctrl;
    toeq_pkg::t_entry s_new;
    toeq_pkg::t_slot  s_slot  [QUEUE_DEPTH];
    logic             s_place [QUEUE_DEPTH];
    toeq_pkg::t_kind  s_kind;
    logic             s_accept;
    logic             s_full;
    logic             s_empty;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done;
    toeq_pkg::t_status r_status, n_status;
    toeq_pkg::t_entry r_ev, n_ev;
    logic [CNT_W+toeq_pkg::OCC_W-1:0] s_occ_ext;

    assign busy     = 1'b0;
    assign s_accept = start && !busy;
    assign s_kind   = toeq_pkg::t_kind'(i_kind);
    assign s_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign s_empty  = (r_count == '0);

    assign s_new.ev_time   = i_event_time;
    assign s_new.ev_type   = i_event_type;
    assign s_new.ev_source = i_source_floor;
    assign s_new.ev_dest   = i_dest_floor;

    assign s_ctrl.ins = s_accept && (s_kind == toeq_pkg::K_INSERT) && !s_full;
    assign s_ctrl.pop = s_accept && (s_kind == toeq_pkg::K_POP) && !s_empty;

    // sorted chain; slot 0 holds the earliest event
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            toeq_pkg::t_slot s_left;
            logic            s_left_place;
            toeq_pkg::t_slot s_right;
            if (g == 0) begin : g_first
                assign s_left       = '0;
                assign s_left_place = 1'b0;
            end else begin : g_mid
                assign s_left       = s_slot[g-1];
                assign s_left_place = s_place[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign s_right = '0;
            end else begin : g_inner
                assign s_right = s_slot[g+1];
            end
            toeq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (s_ctrl),
                .i_new        (s_new),
                .i_left       (s_left),
                .i_left_place (s_left_place),
                .i_right      (s_right),
                .o_slot       (s_slot[g]),
                .o_place      (s_place[g])
            );
        end
    endgenerate

    // result formation
    always_comb begin
        n_count  = r_count;
        n_status = toeq_pkg::ST_OK;
        n_ev     = '0;
        case (s_kind)
            toeq_pkg::K_INSERT: begin
                if (s_full) begin
                    n_status = toeq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            toeq_pkg::K_POP, toeq_pkg::K_PEEK: begin
                if (s_empty) begin
                    n_status = toeq_pkg::ST_EMPTY;
                end else begin
                    n_ev = s_slot[0].ev;
                    if (s_kind == toeq_pkg::K_POP) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_status = toeq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= s_accept;
            if (s_accept) begin
                r_count  <= n_count;
                r_status <= n_status;
                r_ev     <= n_ev;
            end
        end
    end

    // occupancy is reported modulo 32
    assign s_occ_ext = {{toeq_pkg::OCC_W{1'b0}}, r_count};

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_out_time   = r_ev.ev_time;
    assign o_out_type   = r_ev.ev_type;
    assign o_out_source = r_ev.ev_source;
    assign o_out_dest   = r_ev.ev_dest;
    assign o_occupancy  = s_occ_ext[toeq_pkg::OCC_W-1:0];

endmodule

`default_nettype wire

// File: rtl/toeq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted chain.
module toeq_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  toeq_pkg::t_ctrl       i_ctrl,
    input  toeq_pkg::t_entry      i_new,
    input  toeq_pkg::t_slot       i_left,
    input  wire                   i_left_place,
    input  toeq_pkg::t_slot       i_right,
    output toeq_pkg::t_slot       o_slot,
    output logic                  o_place
);

    toeq_pkg::t_slot r_slot;
    toeq_pkg::t_slot n_slot;

    // new item lands at or before this slot
    assign o_place = !r_slot.valid || (r_slot.ev.ev_time >= i_new.ev_time);
    assign o_slot  = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.ins) begin
            if (i_left_place) begin
                n_slot = i_left;
            end else if (o_place) begin
                n_slot.valid = 1'b1;
                n_slot.ev    = i_new;
            end
        end else if (i_ctrl.pop) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

`default_nettype wire
